[hdl/blc4_pkg.sv]
// Shared types and constants of the four-axis backlash compensation block.
package blc4_pkg;

  // Axis count and axis positions inside per-axis arrays
  localparam int unsigned NumAxes = 4;
  localparam int unsigned AxisX   = 0;
  localparam int unsigned AxisY   = 1;
  localparam int unsigned AxisZ   = 2;
  localparam int unsigned AxisE   = 3;

  // Field widths
  localparam int unsigned PosW  = 32;
  localparam int unsigned BackW = 16;

  typedef logic signed [PosW-1:0]  pos_t;
  typedef logic signed [BackW-1:0] back_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BACKLASH_X = 2'd0,
    REG_BACKLASH_Y = 2'd1,
    REG_BACKLASH_Z = 2'd2,
    REG_BACKLASH_E = 2'd3
  } reg_idx_e;

  // Per-lane result handed to the merge stage
  typedef struct packed {
    pos_t adj;
    pos_t total;
    logic corr;
  } lane_res_t;

  // One complete result item as held in the output buffer
  typedef struct packed {
    pos_t [NumAxes-1:0] adj;
    pos_t [NumAxes-1:0] total;
    logic               corrected;
  } result_t;

endpackage

[hdl/blc4_if.sv]
// Channel interfaces: move input, result output and configuration write.

interface blc4_in_if;
  logic              valid;
  logic              ready;
  blc4_pkg::pos_t    cur_x;
  blc4_pkg::pos_t    cur_y;
  blc4_pkg::pos_t    cur_z;
  blc4_pkg::pos_t    cur_e;
  blc4_pkg::pos_t    dst_x;
  blc4_pkg::pos_t    dst_y;
  blc4_pkg::pos_t    dst_z;
  blc4_pkg::pos_t    dst_e;

  modport source (
    output valid, cur_x, cur_y, cur_z, cur_e, dst_x, dst_y, dst_z, dst_e,
    input  ready
  );
  modport sink (
    input  valid, cur_x, cur_y, cur_z, cur_e, dst_x, dst_y, dst_z, dst_e,
    output ready
  );
endinterface

interface blc4_out_if;
  logic              valid;
  logic              ready;
  blc4_pkg::pos_t    adj_x;
  blc4_pkg::pos_t    adj_y;
  blc4_pkg::pos_t    adj_z;
  blc4_pkg::pos_t    adj_e;
  blc4_pkg::pos_t    total_x;
  blc4_pkg::pos_t    total_y;
  blc4_pkg::pos_t    total_z;
  blc4_pkg::pos_t    total_e;
  logic              corrected;

  modport source (
    output valid, adj_x, adj_y, adj_z, adj_e,
           total_x, total_y, total_z, total_e, corrected,
    input  ready
  );
  modport sink (
    input  valid, adj_x, adj_y, adj_z, adj_e,
           total_x, total_y, total_z, total_e, corrected,
    output ready
  );
endinterface

interface blc4_cfg_if;
  logic                 valid;
  logic                 ready;
  blc4_pkg::reg_idx_e   index;
  blc4_pkg::back_t      data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

[hdl/blc4_lane.sv]
// One axis lane: direction detect, reversal correction and axis state.
module blc4_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  blc4_pkg::back_t     cfg_data_i,
  input  logic                in_fire_i,
  input  blc4_pkg::pos_t      cur_i,
  input  blc4_pkg::pos_t      dst_i,
  output blc4_pkg::lane_res_t res_o
);

  blc4_pkg::back_t backlash_q;
  blc4_pkg::pos_t  shift_sum_q, shift_sum_d;
  logic            last_dir_q, last_dir_d;

  logic            dir, mov, do_fix;
  blc4_pkg::pos_t  back_ext, fix;

  // Hold the backlash step count; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backlash_q <= '0;
    end else if (cfg_we_i) begin
      backlash_q <= cfg_data_i;
    end
  end

  // Find direction and movement, then the correction for a reversal
  always_comb begin
    dir      = (dst_i < cur_i);
    mov      = (dst_i != cur_i);
    do_fix   = mov && (dir != last_dir_q) && (backlash_q != '0);
    back_ext = blc4_pkg::pos_t'(backlash_q);
    fix      = dir ? (blc4_pkg::pos_t'(0) - back_ext) : back_ext;

    res_o.adj   = do_fix ? (cur_i - fix) : cur_i;
    res_o.total = do_fix ? (shift_sum_q + fix) : shift_sum_q;
    res_o.corr  = do_fix;

    shift_sum_d = res_o.total;
    last_dir_d  = mov ? dir : last_dir_q;
  end

  // Advance the axis state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_sum_q <= '0;
      last_dir_q  <= 1'b0;
    end else if (in_fire_i) begin
      shift_sum_q <= shift_sum_d;
      last_dir_q  <= last_dir_d;
    end
  end

`ifndef SYNTH
  // A move without correction leaves the running total alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && !do_fix) |=> (shift_sum_q == $past(shift_sum_q)))
    else $error("shift total changed without a correction");

  // Direction memory changes only on an accepted moving item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire_i && mov) |=> $stable(last_dir_q))
    else $error("last direction changed without a move");
`endif

endmodule

[hdl/blc4_merge.sv]
// Merge stage: combines lane results and buffers items toward the output.
module blc4_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blc4_pkg::lane_res_t res_i [blc4_pkg::NumAxes],
  input  logic                in_fire_i,
  output logic                in_ready_o,
  blc4_out_if.source          out_o
);

  blc4_pkg::result_t new_item;
  blc4_pkg::result_t main_q, main_d, skid_q, skid_d;
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  logic              out_fire;

  // Gather lane outputs and OR the correction flags
  always_comb begin
    new_item.corrected = 1'b0;
    for (int unsigned k = 0; k < blc4_pkg::NumAxes; k++) begin
      new_item.adj[k]    = res_i[k].adj;
      new_item.total[k]  = res_i[k].total;
      new_item.corrected = new_item.corrected | res_i[k].corr;
    end
  end

  assign out_fire   = out_valid_q && out_o.ready;
  assign in_ready_o = !skid_valid_q;

  // Refill the output register from skid or new item; park on a stall
  always_comb begin
    main_d       = main_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (in_fire_i) begin
        main_d      = new_item;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_fire_i) begin
      skid_d       = new_item;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // Drive the output channel
  assign out_o.valid     = out_valid_q;
  assign out_o.adj_x     = main_q.adj[blc4_pkg::AxisX];
  assign out_o.adj_y     = main_q.adj[blc4_pkg::AxisY];
  assign out_o.adj_z     = main_q.adj[blc4_pkg::AxisZ];
  assign out_o.adj_e     = main_q.adj[blc4_pkg::AxisE];
  assign out_o.total_x   = main_q.total[blc4_pkg::AxisX];
  assign out_o.total_y   = main_q.total[blc4_pkg::AxisY];
  assign out_o.total_z   = main_q.total[blc4_pkg::AxisZ];
  assign out_o.total_e   = main_q.total[blc4_pkg::AxisE];
  assign out_o.corrected = main_q.corrected;

`ifndef SYNTH
  // The skid entry never holds an item while the output register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  // An item accepted during a stall lands in the skid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready && in_fire_i) |=> skid_valid_q)
    else $error("item dropped during output stall");

  // A parked item moves up when the output is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_fire) |=> (out_valid_q && !skid_valid_q))
    else $error("skid item not promoted");
`endif

endmodule

[hdl/backlash_compensation_4axis_core.sv]
// Top level of the four-axis backlash compensation block.
//
// Usage:
//   in_i   takes one planned move per item: current and destination position
//          in steps for X, Y, Z and E. An item is taken when valid and ready
//          are both high.
//   out_o  gives one result per move: corrected start positions, running
//          shift totals per axis and a flag that some axis was corrected.
//   cfg_i  writes the per-axis backlash step counts (index 0..3 = X, Y, Z, E).
//          Always ready; write only while no move is in flight.
// Result: lanes are combinational; the merge stage registers the result.
// Throughput: one move per cycle while in_i.ready is high. Each axis lane does
//   one signed compare, a negate and two 32-bit adds per cycle, with its
//   direction bit and shift total updated on the same edge that takes the move.
// Stall: a two-entry output buffer keeps taking moves while one result waits;
//   in_i.ready drops only when both entries are full.
// Reset: backlash counts, shift totals and directions clear to zero (all
//   axes positive); the output buffer empties.
module backlash_compensation_4axis_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  blc4_in_if.sink   in_i,
  blc4_out_if.source out_o,
  blc4_cfg_if.sink  cfg_i
);

  logic                in_fire, in_ready;
  logic                cfg_fire;
  logic                cfg_we [blc4_pkg::NumAxes];
  blc4_pkg::pos_t      cur    [blc4_pkg::NumAxes];
  blc4_pkg::pos_t      dst    [blc4_pkg::NumAxes];
  blc4_pkg::lane_res_t res    [blc4_pkg::NumAxes];

  assign in_i.ready  = in_ready;
  assign in_fire     = in_i.valid && in_ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  // Spread the move over the axis lanes
  assign cur[blc4_pkg::AxisX] = in_i.cur_x;
  assign cur[blc4_pkg::AxisY] = in_i.cur_y;
  assign cur[blc4_pkg::AxisZ] = in_i.cur_z;
  assign cur[blc4_pkg::AxisE] = in_i.cur_e;
  assign dst[blc4_pkg::AxisX] = in_i.dst_x;
  assign dst[blc4_pkg::AxisY] = in_i.dst_y;
  assign dst[blc4_pkg::AxisZ] = in_i.dst_z;
  assign dst[blc4_pkg::AxisE] = in_i.dst_e;

  // Decode the register index to a lane write enable
  always_comb begin
    for (int unsigned k = 0; k < blc4_pkg::NumAxes; k++) begin
      cfg_we[k] = 1'b0;
    end
    case (cfg_i.index)
      blc4_pkg::REG_BACKLASH_X: cfg_we[blc4_pkg::AxisX] = cfg_fire;
      blc4_pkg::REG_BACKLASH_Y: cfg_we[blc4_pkg::AxisY] = cfg_fire;
      blc4_pkg::REG_BACKLASH_Z: cfg_we[blc4_pkg::AxisZ] = cfg_fire;
      blc4_pkg::REG_BACKLASH_E: cfg_we[blc4_pkg::AxisE] = cfg_fire;
      default: ;
    endcase
  end

  // One lane per axis
  for (genvar g = 0; g < blc4_pkg::NumAxes; g++) begin : g_lane
    blc4_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_we_i   (cfg_we[g]),
      .cfg_data_i (cfg_i.data),
      .in_fire_i  (in_fire),
      .cur_i      (cur[g]),
      .dst_i      (dst[g]),
      .res_o      (res[g])
    );
  end

  // Combine lane results and buffer toward the output
  blc4_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .in_fire_i  (in_fire),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

endmodule

[tb/sv/backlash_compensation_4axis_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for the four-axis backlash compensation core, checked against its own predictor.
module backlash_compensation_4axis_core_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;
  localparam blc4_pkg::pos_t PosMax = 32'sh7fff_ffff;
  localparam blc4_pkg::pos_t PosMin = 32'sh8000_0000;
  localparam blc4_pkg::back_t BackMax = 16'sh7fff;
  localparam blc4_pkg::back_t BackMin = 16'sh8000;

  typedef struct packed {
    blc4_pkg::pos_t [blc4_pkg::NumAxes-1:0] cur;
    blc4_pkg::pos_t [blc4_pkg::NumAxes-1:0] dst;
  } move_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  blc4_in_if  in_if ();
  blc4_out_if out_if ();
  blc4_cfg_if cfg_if ();

  backlash_compensation_4axis_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Predictor state: backlash counts, last direction per axis, shift totals
  blc4_pkg::back_t              backlash_steps [blc4_pkg::NumAxes];
  logic [blc4_pkg::NumAxes-1:0] last_neg;
  blc4_pkg::pos_t               shift_total [blc4_pkg::NumAxes];

  blc4_pkg::result_t pending_results [$];
  int      fail_count;
  int      results_seen;
  int      cycle_count = 0;
  int      hold_request;
  bit      no_idle;

  always #10 clk_i = ~clk_i;

  // End the run on a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Work out the corrected positions and totals for one move, advance state
  function automatic blc4_pkg::result_t compensate_move(input move_t m);
    blc4_pkg::result_t            r;
    logic [blc4_pkg::NumAxes-1:0] neg;
    logic [blc4_pkg::NumAxes-1:0] moving;
    logic [blc4_pkg::NumAxes-1:0] flip;
    blc4_pkg::pos_t               fix;
    r.corrected = 1'b0;
    for (int i = 0; i < blc4_pkg::NumAxes; i++) begin
      r.adj[i]  = m.cur[i];
      neg[i]    = $signed(m.dst[i]) < $signed(m.cur[i]);
      moving[i] = m.dst[i] != m.cur[i];
    end
    flip = (neg ^ last_neg) & moving;
    for (int i = 0; i < blc4_pkg::NumAxes; i++) begin
      if (flip[i] && backlash_steps[i] != 0) begin
        fix = blc4_pkg::pos_t'(backlash_steps[i]);
        if (neg[i]) fix = -fix;
        r.adj[i]       = r.adj[i] - fix;
        shift_total[i] = shift_total[i] + fix;
        r.corrected    = 1'b1;
      end
      r.total[i] = shift_total[i];
    end
    last_neg = (neg & moving) | (last_neg & ~moving);
    return r;
  endfunction

  function automatic move_t uniform_move(input blc4_pkg::pos_t c, input blc4_pkg::pos_t d);
    move_t m;
    for (int i = 0; i < blc4_pkg::NumAxes; i++) begin
      m.cur[i] = c;
      m.dst[i] = d;
    end
    return m;
  endfunction

  function automatic blc4_pkg::pos_t extreme_pos();
    case ($urandom_range(0, 4))
      0: return PosMax;
      1: return PosMin;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // Mix of still axes, short moves, wide moves and moves near the wrap points
  function automatic move_t random_move();
    move_t          m;
    blc4_pkg::pos_t delta;
    for (int i = 0; i < blc4_pkg::NumAxes; i++) begin
      delta = blc4_pkg::pos_t'($urandom_range(1, 1000));
      if ($urandom_range(0, 1)) delta = -delta;
      case ($urandom_range(0, 9))
        0, 1: begin
          m.cur[i] = blc4_pkg::pos_t'($urandom);
          m.dst[i] = m.cur[i];
        end
        2, 3, 4, 5: begin
          m.cur[i] = blc4_pkg::pos_t'($urandom);
          m.dst[i] = m.cur[i] + delta;
        end
        6, 7: begin
          m.cur[i] = blc4_pkg::pos_t'($urandom);
          m.dst[i] = blc4_pkg::pos_t'($urandom);
        end
        8: begin
          m.cur[i] = extreme_pos();
          m.dst[i] = extreme_pos();
        end
        default: begin
          m.cur[i] = extreme_pos();
          m.dst[i] = m.cur[i] + delta;
        end
      endcase
    end
    return m;
  endfunction

  // Offer one move, hold it until taken, then queue its expected result
  task automatic send_move(input move_t m);
    bit take;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cur_x <= m.cur[blc4_pkg::AxisX];
    in_if.cur_y <= m.cur[blc4_pkg::AxisY];
    in_if.cur_z <= m.cur[blc4_pkg::AxisZ];
    in_if.cur_e <= m.cur[blc4_pkg::AxisE];
    in_if.dst_x <= m.dst[blc4_pkg::AxisX];
    in_if.dst_y <= m.dst[blc4_pkg::AxisY];
    in_if.dst_z <= m.dst[blc4_pkg::AxisZ];
    in_if.dst_e <= m.dst[blc4_pkg::AxisE];
    do begin
      @(negedge clk_i);
      take = in_if.ready;
      @(posedge clk_i);
    end while (!take);
    pending_results.push_back(compensate_move(m));
  endtask

  // Drop valid and wait until every expected result is out
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write all four backlash registers back to back
  task automatic write_backlash(input blc4_pkg::back_t vals [blc4_pkg::NumAxes]);
    bit take;
    for (int i = 0; i < blc4_pkg::NumAxes; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= blc4_pkg::reg_idx_e'(i);
      cfg_if.data  <= vals[i];
      do begin
        @(negedge clk_i);
        take = cfg_if.ready;
        @(posedge clk_i);
      end while (!take);
      backlash_steps[i] = vals[i];
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("result %0d: %s", results_seen, msg);
  endtask

  // Compare one taken result with the oldest expectation
  task automatic check_result();
    blc4_pkg::result_t seen;
    blc4_pkg::result_t want;
    seen.adj[blc4_pkg::AxisX]   = out_if.adj_x;
    seen.adj[blc4_pkg::AxisY]   = out_if.adj_y;
    seen.adj[blc4_pkg::AxisZ]   = out_if.adj_z;
    seen.adj[blc4_pkg::AxisE]   = out_if.adj_e;
    seen.total[blc4_pkg::AxisX] = out_if.total_x;
    seen.total[blc4_pkg::AxisY] = out_if.total_y;
    seen.total[blc4_pkg::AxisZ] = out_if.total_z;
    seen.total[blc4_pkg::AxisE] = out_if.total_e;
    seen.corrected              = out_if.corrected;
    if (pending_results.size() == 0) begin
      flag_failure("result with no move pending");
    end else begin
      want = pending_results.pop_front();
      for (int i = 0; i < blc4_pkg::NumAxes; i++) begin
        if (seen.adj[i] !== want.adj[i])
          flag_failure($sformatf("adj axis %0d: expected %0d, got %0d",
                                 i, $signed(want.adj[i]), $signed(seen.adj[i])));
        if (seen.total[i] !== want.total[i])
          flag_failure($sformatf("total axis %0d: expected %0d, got %0d",
                                 i, $signed(want.total[i]), $signed(seen.total[i])));
      end
      if (seen.corrected !== want.corrected)
        flag_failure($sformatf("corrected: expected %0b, got %0b",
                               want.corrected, seen.corrected));
    end
    results_seen++;
  endtask

  // Sample the result channel where nothing is changing
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_result();
    end
  end

  // Drive result ready: long hold-offs on request, always ready in no-idle phases, random stall bursts otherwise
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        out_if.ready <= 1'b0;
        hold_request--;
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 18);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // First move after reset runs against all-positive directions
  task automatic test_first_move();
    write_backlash('{16'sd100, -16'sd7, BackMax, BackMin});
    send_move(uniform_move(32'sd1000, 32'sd0));
    send_move(uniform_move(32'sd0, 32'sd1000));
  endtask

  // Field extremes, still axes and wrap of the corrected position
  task automatic test_field_extremes();
    move_t m;
    send_move(uniform_move(PosMax, PosMin));
    send_move(uniform_move(PosMax, PosMax));
    send_move(uniform_move(PosMax - 3, PosMax));
    send_move(uniform_move(PosMin, PosMax));
    send_move(uniform_move(PosMin + 5, PosMin));
    send_move(uniform_move(PosMax, PosMin));
    send_move(uniform_move(32'sd0, -32'sd1));
    send_move(uniform_move(-32'sd1, 32'sd0));
    send_move(uniform_move(32'sd0, 32'sd0));
    m = uniform_move(32'sd5, -32'sd10);
    m.dst[blc4_pkg::AxisY] = 32'sd5;
    m.dst[blc4_pkg::AxisE] = 32'sd5;
    send_move(m);
    m = uniform_move(-32'sd10, 32'sd7);
    m.dst[blc4_pkg::AxisX] = -32'sd10;
    send_move(m);
  endtask

  // Zero registers disable correction but keep direction tracking
  task automatic test_disabled_axes();
    settle();
    write_backlash('{16'sd0, 16'sd1, 16'sd0, -16'sd1});
    send_move(uniform_move(32'sd10, 32'sd20));
    send_move(uniform_move(32'sd20, 32'sd10));
    send_move(uniform_move(32'sd10, 32'sd20));
    settle();
    write_backlash('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_move(uniform_move(32'sd20, 32'sd10));
    send_move(uniform_move(32'sd10, 32'sd20));
    send_move(uniform_move(32'sd20, 32'sd10));
    settle();
    write_backlash('{BackMax, BackMin, 16'sd1, -16'sd1});
    send_move(uniform_move(32'sd10, 32'sd20));
    send_move(uniform_move(32'sd20, 32'sd20));
    send_move(uniform_move(32'sd20, 32'sd10));
  endtask

  task automatic run_random_phase(input blc4_pkg::back_t vals [blc4_pkg::NumAxes],
                                  input int count);
    settle();
    write_backlash(vals);
    repeat (count) send_move(random_move());
  endtask

  // Hold off the result side while moves keep coming, so input stalls
  task automatic test_backpressure();
    hold_request = 150;
    repeat (30) send_move(random_move());
  endtask

  initial begin
    for (int i = 0; i < blc4_pkg::NumAxes; i++) begin
      backlash_steps[i] = '0;
      shift_total[i]    = '0;
    end
    last_neg     = '0;
    fail_count   = 0;
    results_seen = 0;
    hold_request = 0;
    no_idle      = 1'b0;
    in_if.valid  = 1'b0;
    in_if.cur_x  = '0;
    in_if.cur_y  = '0;
    in_if.cur_z  = '0;
    in_if.cur_e  = '0;
    in_if.dst_x  = '0;
    in_if.dst_y  = '0;
    in_if.dst_z  = '0;
    in_if.dst_e  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = blc4_pkg::REG_BACKLASH_X;
    cfg_if.data  = '0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_move();
    test_field_extremes();
    test_disabled_axes();

    run_random_phase('{BackMax, BackMax, BackMax, BackMax}, 250);
    run_random_phase('{BackMin, BackMin, BackMin, BackMin}, 250);
    run_random_phase('{blc4_pkg::back_t'($urandom), blc4_pkg::back_t'($urandom),
                       blc4_pkg::back_t'($urandom), blc4_pkg::back_t'($urandom)}, 300);
    run_random_phase('{16'sd0, BackMax, BackMin, blc4_pkg::back_t'($urandom)}, 250);
    no_idle = 1'b1;
    run_random_phase('{blc4_pkg::back_t'(int'($urandom_range(0, 100)) - 50),
                       blc4_pkg::back_t'(int'($urandom_range(0, 100)) - 50),
                       blc4_pkg::back_t'(int'($urandom_range(0, 100)) - 50),
                       blc4_pkg::back_t'(int'($urandom_range(0, 100)) - 50)}, 250);
    no_idle = 1'b0;
    run_random_phase('{blc4_pkg::back_t'($urandom), 16'sd0,
                       blc4_pkg::back_t'($urandom), 16'sd1}, 250);
    test_backpressure();
    no_idle = 1'b1;
    run_random_phase('{blc4_pkg::back_t'($urandom), blc4_pkg::back_t'($urandom),
                       blc4_pkg::back_t'($urandom), blc4_pkg::back_t'($urandom)}, 250);

    // Drain, then wait for any stray result to show up
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/blc4_pkg.sv
hdl/blc4_if.sv
hdl/blc4_lane.sv
hdl/blc4_merge.sv
hdl/backlash_compensation_4axis_core.sv
tb/sv/backlash_compensation_4axis_core_tb.sv
